// ----- sv/sdtf_pkg.sv -----
// Shared types, constants and command structs of the swept dual-tap delay filter.
package sdtf_pkg;

	localparam int DELAY_DEPTH  = 2048;
	localparam int SAMPLE_WIDTH = 24;
	localparam int ADDR_W       = $clog2(DELAY_DEPTH);
	localparam int FILL_W       = $clog2(DELAY_DEPTH + 1);
	localparam int SW           = SAMPLE_WIDTH;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		sample_t sample_left;
		sample_t sample_right;
	} in_item_t;

	typedef struct packed {
		sample_t out_left;
		sample_t out_right;
	} out_item_t;

	// Configuration register indexes
	localparam logic [1:0] REG_DEPTH_TARGET = 2'd0;
	localparam logic [1:0] REG_WET_MIX      = 2'd1;
	localparam logic [1:0] REG_RATE_SCALE   = 2'd2;

	localparam logic [16:0] UNITY_Q16    = 17'd65536;
	localparam logic [16:0] DEPTH_RESET  = 17'd32768;
	localparam logic [14:0] RATE_MIN     = 15'd4096;
	localparam logic [14:0] RATE_MAX     = 15'd17833;

	// Clamped configuration as seen by the datapath
	typedef struct packed {
		logic [16:0] depth_target;
		logic [16:0] wet_mix;
		logic [14:0] rate_scale;
	} cfg_t;

	// Depth arithmetic constants
	localparam logic [20:0] SMOOTH_COEF = 21'd1288490;   // 0.0003 in Q0.32
	localparam logic [6:0]  OFF_MUL     = 7'd77;
	localparam logic [22:0] OFFA_BIAS   = 23'd209715;
	localparam logic [29:0] OFFB_RND    = 30'd10;
	localparam logic [24:0] OFFB_BIAS   = 25'd2686976;   // 41 in Q.16
	localparam logic [31:0] RECIP5      = 32'hCCCCCCCD;

	// Tap weights, Q.16
	localparam logic signed [17:0] COEF_A_SIDE = 18'sd25625;
	localparam logic signed [17:0] COEF_A_OUT  = 18'sd17957;
	localparam logic signed [17:0] COEF_B_SIDE = 18'sd60162;
	localparam logic signed [17:0] COEF_B_OUT  = 18'sd41222;

	localparam logic signed [SW+3:0] SAT_HI = (SW+4)'(2**(SW-1) - 1);
	localparam logic signed [SW+3:0] SAT_LO = -(SW+4)'(2**(SW-1));

	// Last step index of each sequencer state
	localparam logic [2:0] DSTEP_LAST = 3'd6;
	localparam logic [2:0] RSTEP_LAST = 3'd6;
	localparam logic [2:0] MSTEP_LAST = 3'd4;

	typedef struct packed {
		logic       capture;
		logic       depth_en;
		logic       write_en;
		logic       read_en;
		logic       math_en;
		logic       finish;
		logic [2:0] step;
	} cmd_t;

	typedef struct packed {
		logic sample_valid;
		logic out_free;
	} sts_t;

endpackage

// ----- sv/sdtf_lane.sv -----
// One channel: delay ring memory, tap capture and filter/mix arithmetic.
module sdtf_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdtf_pkg::cmd_t                cmd,
	input  sdtf_pkg::sample_t             x,
	input  logic [sdtf_pkg::ADDR_W-1:0]   addr,
	input  logic                          addr_ok,
	input  logic [16:0]                   wet,
	output sdtf_pkg::sample_t             res
);
	localparam int SW = sdtf_pkg::SW;

	sdtf_pkg::sample_t ring_mem [sdtf_pkg::DELAY_DEPTH];
	sdtf_pkg::sample_t rd_q;
	sdtf_pkg::sample_t tap_q [6];
	logic              rd_en_s1;
	logic [2:0]        rd_idx_s1;
	logic              rd_ok_s1;

	logic signed [SW+17:0] sa_q, sb_q, ca_q, cb_q;
	logic signed [SW+8:0]  y_q;
	logic signed [SW+26:0] p1_q;
	logic signed [SW+17:0] p2_q;
	sdtf_pkg::sample_t     res_q;

	logic signed [SW:0]    pa_c, pb_c;
	logic signed [SW+17:0] sa_c, sb_c, sa_r, sb_r;
	logic signed [SW+9:0]  ra_c, rb_c;
	logic signed [SW+25:0] pca_c, pcb_c;
	logic signed [SW+18:0] acc_c;
	logic [16:0]           dry_c;
	logic signed [SW+26:0] p1_c;
	logic signed [SW+17:0] p2_c;
	logic signed [SW+27:0] m_c;
	logic signed [SW+3:0]  r_c;
	sdtf_pkg::sample_t     sat_c;

	always_ff @(posedge clk) begin
		if (cmd.write_en) begin
			ring_mem[addr] <= x;
		end else if (cmd.read_en) begin
			rd_q <= ring_mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_en_s1 <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.read_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.step;
		rd_ok_s1  <= addr_ok;
		// unwritten entries read as zero
		if (rd_en_s1) begin
			tap_q[rd_idx_s1] <= rd_ok_s1 ? rd_q : '0;
		end
	end

	always_comb begin
		pa_c  = (SW+1)'(tap_q[0]) + (SW+1)'(tap_q[2]);
		pb_c  = (SW+1)'(tap_q[3]) + (SW+1)'(tap_q[5]);
		sa_c  = (SW+18)'(pa_c) * (SW+18)'(sdtf_pkg::COEF_A_SIDE)
			+ ((SW+18)'(tap_q[1]) <<< 16);
		sb_c  = (SW+18)'(pb_c) * (SW+18)'(sdtf_pkg::COEF_B_SIDE)
			+ ((SW+18)'(tap_q[4]) <<< 16);
		sa_r  = sa_q + (SW+18)'(128);
		sb_r  = sb_q + (SW+18)'(128);
		ra_c  = sa_r[SW+17:8];
		rb_c  = sb_r[SW+17:8];
		pca_c = (SW+26)'(ra_c) * (SW+26)'(sdtf_pkg::COEF_A_OUT) + (SW+26)'(128);
		pcb_c = (SW+26)'(rb_c) * (SW+26)'(sdtf_pkg::COEF_B_OUT) + (SW+26)'(128);
		acc_c = ((SW+19)'(x) <<< 16) + (SW+19)'(ca_q) - (SW+19)'(cb_q)
			+ (SW+19)'(512);
		dry_c = sdtf_pkg::UNITY_Q16 - wet;
		p1_c  = (SW+27)'(y_q) * (SW+27)'(signed'({1'b0, wet}));
		p2_c  = (SW+18)'(x) * (SW+18)'(signed'({1'b0, dry_c}));
		m_c   = (SW+28)'(p1_q) + ((SW+28)'(p2_q) <<< 8) + (SW+28)'(2**23);
		r_c   = m_c[SW+27:24];
		if (r_c > sdtf_pkg::SAT_HI) begin
			sat_c = sdtf_pkg::SAT_HI[SW-1:0];
		end else if (r_c < sdtf_pkg::SAT_LO) begin
			sat_c = sdtf_pkg::SAT_LO[SW-1:0];
		end else begin
			sat_c = r_c[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.math_en) begin
			case (cmd.step)
				3'd0: begin
					sa_q <= sa_c;
					sb_q <= sb_c;
				end
				3'd1: begin
					ca_q <= pca_c[SW+25:8];
					cb_q <= pcb_c[SW+25:8];
				end
				3'd2: begin
					y_q <= acc_c[SW+18:10];
				end
				3'd3: begin
					p1_q <= p1_c;
					p2_q <= p2_c;
				end
				3'd4: begin
					res_q <= sat_c;
				end
				default: begin
				end
			endcase
		end
	end

	assign res = res_q;

endmodule

// ----- sv/sdtf_dp.sv -----
// Datapath: depth smoothing, delay and address generation, two lanes, output register.
module sdtf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdtf_pkg::cmd_t       cmd,
	input  sdtf_pkg::cfg_t       cfg,
	input  sdtf_pkg::in_item_t   sample,
	input  logic                 result_stall,
	output logic                 out_free,
	output logic                 result_valid,
	output sdtf_pkg::out_item_t  result
);
	localparam int AW = sdtf_pkg::ADDR_W;
	localparam int FW = sdtf_pkg::FILL_W;

	sdtf_pkg::in_item_t  x_q;
	sdtf_pkg::out_item_t out_q;
	logic                out_valid_q;
	logic [23:0]         sd_q;
	logic [AW-1:0]       wp_q;
	logic [FW-1:0]       fill_q;

	logic signed [46:0]  prod_q;
	logic [16:0]         sq_q;
	logic [22:0]         offa_q;
	logic [29:0]         n77_q;
	logic [24:0]         offb_q;
	logic [10:0]         da_q, db_q;

	logic signed [24:0]  diff_c;
	logic signed [46:0]  prod_c, prod_r;
	logic signed [24:0]  sd_sum_c;
	logic [47:0]         sqp_c;
	logic [37:0]         dap_c;
	logic [58:0]         q5_c;
	logic [39:0]         dbp_c;
	logic [2:0]          wa_c;
	logic [17:0]         wb7_c;
	logic [5:0]          wb_c;
	logic [FW-1:0]       k_c;
	logic [AW:0]         sum_c, wrap_c;
	logic [AW-1:0]       addr_c;
	logic                addr_ok_c;
	sdtf_pkg::sample_t   res_l, res_r;

	always_comb begin
		diff_c   = signed'({1'b0, cfg.depth_target, 7'b0}) - signed'({1'b0, sd_q});
		prod_c   = 47'(diff_c) * 47'(signed'({1'b0, sdtf_pkg::SMOOTH_COEF}));
		prod_r   = prod_q + 47'sh80000000;
		sd_sum_c = signed'({1'b0, sd_q}) + 25'(signed'(prod_r[46:32]));
		sqp_c    = 48'(sd_q) * 48'(sd_q) + 48'h20000000;
		dap_c    = 38'(offa_q) * 38'(cfg.rate_scale);
		q5_c     = 59'(n77_q[29:2]) * 59'(sdtf_pkg::RECIP5);
		dbp_c    = 40'(offb_q) * 40'(cfg.rate_scale);
		wa_c     = cfg.rate_scale[14:12];
		wb7_c    = 18'(cfg.rate_scale) * 18'd7;
		wb_c     = wb7_c[17:12];

		case (cmd.step)
			3'd0:    k_c = FW'(da_q);
			3'd1:    k_c = FW'(da_q) + FW'(wa_c);
			3'd2:    k_c = FW'(da_q) + FW'({wa_c, 1'b0});
			3'd3:    k_c = FW'(db_q);
			3'd4:    k_c = FW'(db_q) + FW'(wb_c);
			3'd5:    k_c = FW'(db_q) + FW'({wb_c, 1'b0});
			default: k_c = FW'(da_q);
		endcase

		sum_c = (AW+1)'(wp_q) + (AW+1)'(k_c);
		if (sum_c >= (AW+1)'(sdtf_pkg::DELAY_DEPTH)) begin
			wrap_c = sum_c - (AW+1)'(sdtf_pkg::DELAY_DEPTH);
		end else begin
			wrap_c = sum_c;
		end
		addr_c    = cmd.write_en ? wp_q : wrap_c[AW-1:0];
		// a tap reaching past the samples taken so far reads zero
		addr_ok_c = (k_c <= fill_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q <= sample;
		end
		if (cmd.depth_en) begin
			case (cmd.step)
				3'd0: prod_q <= prod_c;
				3'd2: sq_q   <= sqp_c[46:30];
				3'd3: offa_q <= 23'(sq_q) * 23'(sdtf_pkg::OFF_MUL) + sdtf_pkg::OFFA_BIAS;
				3'd4: begin
					n77_q <= 30'(offa_q) * 30'(sdtf_pkg::OFF_MUL) + sdtf_pkg::OFFB_RND;
					da_q  <= 11'(dap_c[37:28]);
				end
				3'd5: offb_q <= q5_c[58:34] + sdtf_pkg::OFFB_BIAS;
				3'd6: db_q   <= dbp_c[38:28];
				default: begin
				end
			endcase
		end
		if (cmd.finish) begin
			out_q <= '{out_left: res_l, out_right: res_r};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sd_q        <= '0;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.depth_en && cmd.step == 3'd1) begin
				sd_q <= sd_sum_c[23:0];
			end
			if (cmd.finish) begin
				wp_q <= (wp_q == '0) ? AW'(sdtf_pkg::DELAY_DEPTH - 1) : wp_q - AW'(1);
				if (fill_q != FW'(sdtf_pkg::DELAY_DEPTH)) begin
					fill_q <= fill_q + FW'(1);
				end
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	sdtf_lane u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.x       (x_q.sample_left),
		.addr    (addr_c),
		.addr_ok (addr_ok_c),
		.wet     (cfg.wet_mix),
		.res     (res_l)
	);

	sdtf_lane u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.x       (x_q.sample_right),
		.addr    (addr_c),
		.addr_ok (addr_ok_c),
		.wet     (cfg.wet_mix),
		.res     (res_r)
	);

	assign out_free     = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !result_stall))
		else $error("result loaded over a waiting result");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(sdtf_pkg::DELAY_DEPTH))
		else $error("fill count beyond ring depth");

endmodule

// ----- sv/sdtf_ctrl.sv -----
// Sequencer: steps one request through depth update, ring access and filter math.
module sdtf_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  sdtf_pkg::sts_t  sts,
	output sdtf_pkg::cmd_t  cmd,
	output logic            busy
);
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_DEPTH  = 6'b000010,
		ST_WRITE  = 6'b000100,
		ST_READ   = 6'b001000,
		ST_MATH   = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.step = cnt_q;
		busy    = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = sts.sample_valid;
				if (sts.sample_valid) begin
					state_d = ST_DEPTH;
					cnt_d   = '0;
				end
			end
			ST_DEPTH: begin
				cmd.depth_en = 1'b1;
				cnt_d        = cnt_q + 3'd1;
				if (cnt_q == sdtf_pkg::DSTEP_LAST) begin
					state_d = ST_WRITE;
					cnt_d   = '0;
				end
			end
			ST_WRITE: begin
				cmd.write_en = 1'b1;
				state_d      = ST_READ;
			end
			ST_READ: begin
				// last count only drains the read pipe
				cmd.read_en = (cnt_q != sdtf_pkg::RSTEP_LAST);
				cnt_d       = cnt_q + 3'd1;
				if (cnt_q == sdtf_pkg::RSTEP_LAST) begin
					state_d = ST_MATH;
					cnt_d   = '0;
				end
			end
			ST_MATH: begin
				cmd.math_en = 1'b1;
				cnt_d       = cnt_q + 3'd1;
				if (cnt_q == sdtf_pkg::MSTEP_LAST) begin
					state_d = ST_FINISH;
					cnt_d   = '0;
				end
			end
			ST_FINISH: begin
				// hold until the output register can take the result
				cmd.finish = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
				cnt_d   = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_capture_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (cmd.depth_en && cmd.step == 3'd0))
		else $error("depth update did not follow capture");
	a_write_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_en |=> (cmd.read_en && cmd.step == 3'd0))
		else $error("tap reads did not follow ring write");

endmodule

// ----- sv/stereo_swept_dual_tap_delay_filter.sv -----
// Top level of the stereo swept dual-tap delay filter.
// Each stereo request steps from acceptance to a loaded result: accept, the
// chained depth and delay multiplications, write both rings, the six single-port
// ring reads per channel, the filter and mix arithmetic, and the load of the
// output register once it is free. The next request is accepted once the current
// one is loaded, even while that result still waits downstream. Taps that reach
// past the samples taken since reset read as zero, so no clearing pass is needed.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while the block is idle, and the block itself does not enforce it.
module stereo_swept_dual_tap_delay_filter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sdtf_pkg::in_item_t   sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output sdtf_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [16:0]          cfg_data
);
	logic [16:0]    depth_q, wet_q;
	logic [14:0]    rate_q;
	sdtf_pkg::cfg_t cfg_c;
	sdtf_pkg::cmd_t cmd;
	sdtf_pkg::sts_t sts;
	logic           busy;
	logic           out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= sdtf_pkg::DEPTH_RESET;
			wet_q   <= sdtf_pkg::UNITY_Q16;
			rate_q  <= sdtf_pkg::RATE_MIN;
		end else if (cfg_we) begin
			case (cfg_index)
				sdtf_pkg::REG_DEPTH_TARGET: depth_q <= cfg_data;
				sdtf_pkg::REG_WET_MIX:      wet_q   <= cfg_data;
				sdtf_pkg::REG_RATE_SCALE:   rate_q  <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg_c.depth_target = (depth_q > sdtf_pkg::UNITY_Q16) ? sdtf_pkg::UNITY_Q16 : depth_q;
		cfg_c.wet_mix      = (wet_q > sdtf_pkg::UNITY_Q16) ? sdtf_pkg::UNITY_Q16 : wet_q;
		if (rate_q < sdtf_pkg::RATE_MIN) begin
			cfg_c.rate_scale = sdtf_pkg::RATE_MIN;
		end else if (rate_q > sdtf_pkg::RATE_MAX) begin
			cfg_c.rate_scale = sdtf_pkg::RATE_MAX;
		end else begin
			cfg_c.rate_scale = rate_q;
		end
	end

	assign sts.sample_valid = sample_valid;
	assign sts.out_free     = out_free;
	assign sample_stall     = busy;

	sdtf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sdtf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_c),
		.sample       (sample),
		.result_stall (result_stall),
		.out_free     (out_free),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ----- verif/sdtf_checker.sv -----
// Checker of the swept dual-tap delay filter: predicts each stereo result and compares it.
module sdtf_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  sdtf_pkg::in_item_t   sample,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  sdtf_pkg::out_item_t  result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [16:0]          cfg_data,
	output int                   fail_count,
	output int                   pending_count,
	output int                   result_count
);
	logic [16:0] depth_reg;
	logic [16:0] wet_reg;
	logic [14:0] rate_reg;
	longint unsigned depth_smooth;
	int unsigned wpos;
	longint ring_l [sdtf_pkg::DELAY_DEPTH];
	longint ring_r [sdtf_pkg::DELAY_DEPTH];
	sdtf_pkg::out_item_t filtered_q[$];

	function automatic longint round_shift(longint v, int sh);
		longint n;
		n = v + (longint'(1) << (sh - 1));
		return n >>> sh;
	endfunction

	function automatic longint tap_read(bit right, int unsigned k);
		int unsigned a;
		a = (wpos + k) % sdtf_pkg::DELAY_DEPTH;
		return right ? ring_r[a] : ring_l[a];
	endfunction

	function automatic sdtf_pkg::sample_t filter_channel(bit right, longint x,
			int unsigned da, int unsigned wa, int unsigned db, int unsigned wb,
			longint wet);
		longint ta, tb, ca, cb, acc, y, m, r;
		ta = (tap_read(right, da) + tap_read(right, da + 2 * wa)) * 25625
			+ tap_read(right, da + wa) * 65536;
		ca = round_shift(round_shift(ta, 8) * 17957, 8);
		tb = (tap_read(right, db) + tap_read(right, db + 2 * wb)) * 60162
			+ tap_read(right, db + wb) * 65536;
		cb = round_shift(round_shift(tb, 8) * 41222, 8);
		acc = x * 65536 + ca - cb;
		y = round_shift(acc, 10);
		m = y * wet + x * 256 * (65536 - wet);
		r = round_shift(m, 24);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return sdtf_pkg::sample_t'(r);
	endfunction

	task automatic predict_filtered(sdtf_pkg::in_item_t it);
		longint unsigned tgt, wet, rate, s, sq, offa, offb;
		longint diff, xl, xr;
		int unsigned da, db, wa, wb;
		sdtf_pkg::out_item_t o;
		tgt = (depth_reg > sdtf_pkg::UNITY_Q16) ? 64'd65536 : 64'(depth_reg);
		wet = (wet_reg > sdtf_pkg::UNITY_Q16) ? 64'd65536 : 64'(wet_reg);
		rate = 64'(rate_reg);
		if (rate < sdtf_pkg::RATE_MIN) rate = 64'(sdtf_pkg::RATE_MIN);
		if (rate > sdtf_pkg::RATE_MAX) rate = 64'(sdtf_pkg::RATE_MAX);
		diff = longint'(tgt << 7) - longint'(depth_smooth);
		depth_smooth = longint'(depth_smooth) + round_shift(diff * 1288490, 32);
		s = depth_smooth;
		sq = (s * s + (64'd1 << 29)) >> 30;
		offa = 77 * sq + 209715;
		offb = (77 * offa + 10) / 20 + (64'd41 << 16);
		da = 32'((offa * rate) >> 28);
		db = 32'((offb * rate) >> 28);
		wa = 32'(rate >> 12);
		wb = 32'((7 * rate) >> 12);
		xl = it.sample_left;
		xr = it.sample_right;
		ring_l[wpos] = xl;
		ring_r[wpos] = xr;
		o.out_left = filter_channel(0, xl, da, wa, db, wb, longint'(wet));
		o.out_right = filter_channel(1, xr, da, wa, db, wb, longint'(wet));
		filtered_q.push_back(o);
		wpos = (wpos + sdtf_pkg::DELAY_DEPTH - 1) % sdtf_pkg::DELAY_DEPTH;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sdtf_pkg::out_item_t exp_o;
		if (!arst_n) begin
			depth_reg = sdtf_pkg::DEPTH_RESET;
			wet_reg = sdtf_pkg::UNITY_Q16;
			rate_reg = sdtf_pkg::RATE_MIN;
			depth_smooth = 0;
			wpos = 0;
			foreach (ring_l[i]) begin
				ring_l[i] = 0;
				ring_r[i] = 0;
			end
			filtered_q.delete();
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					sdtf_pkg::REG_DEPTH_TARGET: depth_reg = cfg_data;
					sdtf_pkg::REG_WET_MIX: wet_reg = cfg_data;
					sdtf_pkg::REG_RATE_SCALE: rate_reg = cfg_data[14:0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) predict_filtered(sample);
			if (result_valid && !result_stall) begin
				result_count <= result_count + 1;
				if (filtered_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, result);
					fail_count <= fail_count + 1;
				end else begin
					exp_o = filtered_q.pop_front();
					if (exp_o.out_left !== result.out_left) begin
						$display("%0t: out_left expected %0d actual %0d", $time,
							exp_o.out_left, result.out_left);
						fail_count <= fail_count + 1;
					end else if (exp_o.out_right !== result.out_right) begin
						$display("%0t: out_right expected %0d actual %0d", $time,
							exp_o.out_right, result.out_right);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending_count <= filtered_q.size();
	end

endmodule

// ----- verif/tb.sv -----
// Top of the swept dual-tap delay filter testbench: stimulus, configuration phases and verdict.
module tb;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      sample_valid;
	logic      sample_stall;
	sdtf_pkg::in_item_t  sample;
	logic      result_valid;
	logic      result_stall;
	sdtf_pkg::out_item_t result;
	logic      cfg_we;
	logic [1:0] cfg_index;
	logic [16:0] cfg_data;
	int fail_count;
	int pending_count;
	int result_count;
	int idle_cycles;
	int sent_count;
	int stall_mode;

	stereo_swept_dual_tap_delay_filter i_dut (.*);

	sdtf_checker i_checker (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Receiver stall pattern: switch mode now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 0;
				1: result_stall <= ($urandom_range(0, 3) == 0);
				2: result_stall <= ($urandom_range(0, 1) == 0);
				default: result_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) idle_cycles <= 0;
		else if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge clk);
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_pair(logic signed [23:0] l, logic signed [23:0] r);
		sample_valid <= 1;
		sample.sample_left <= l;
		sample.sample_right <= r;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_burst(int n, int kind);
		int gap;
		for (int i = 0; i < n; i++) begin
			case (kind)
				0: send_pair(24'($urandom), 24'($urandom));
				1: send_pair($urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000,
					$urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000);
				default: send_pair($signed(24'($urandom)) >>> $urandom_range(0, 20),
					$signed(24'($urandom)) >>> $urandom_range(0, 20));
			endcase
			if ($urandom_range(0, 7) == 0) begin
				gap = $urandom_range(1, 30);
				sample_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
		sample_valid <= 0;
	endtask

	// Drain outstanding results, then let the pipeline settle.
	task automatic drain;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	initial begin
		logic [16:0] depth_set [6];
		logic [16:0] wet_set [6];
		logic [16:0] rate_set [6];
		depth_set = '{17'd0, 17'd65536, 17'd131071, 17'd1000, 17'd50000, 17'd32768};
		wet_set = '{17'd65536, 17'd0, 17'd131071, 17'd32768, 17'd12345, 17'd65000};
		rate_set = '{17'd4096, 17'd17833, 17'd0, 17'd32767, 17'd8192, 17'd11000};
		arst_n = 0;
		sample_valid = 0;
		sample = '0;
		cfg_we = 0;
		cfg_index = sdtf_pkg::REG_DEPTH_TARGET;
		cfg_data = 0;
		sent_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, zero and the unused register index.
		send_pair(24'sh7FFFFF, 24'sh800000);
		send_pair(24'sh800000, 24'sh7FFFFF);
		send_pair(24'sh000000, 24'sh000000);
		send_pair(24'sh000001, 24'shFFFFFF);
		send_pair(24'sh7FFFFF, 24'sh7FFFFF);
		send_pair(24'sh800000, 24'sh800000);
		sample_valid <= 0;
		drain();
		write_reg(REG_UNUSED, 17'h1FFFF);
		write_reg(sdtf_pkg::REG_DEPTH_TARGET, 17'd65536);
		write_reg(sdtf_pkg::REG_RATE_SCALE, 17'd17833);
		send_burst(12, 1);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(sdtf_pkg::REG_DEPTH_TARGET, depth_set[ph]);
			write_reg(sdtf_pkg::REG_WET_MIX, wet_set[ph]);
			write_reg(sdtf_pkg::REG_RATE_SCALE, rate_set[ph]);
			send_burst(260, ph % 3);
			drain();
			write_reg(sdtf_pkg::REG_DEPTH_TARGET, 17'($urandom));
			write_reg(sdtf_pkg::REG_WET_MIX, 17'($urandom));
			write_reg(sdtf_pkg::REG_RATE_SCALE, 17'($urandom_range(0, 32767)));
		end
		drain();
		$display("Sent %0d stereo requests over 8 register settings, %0d results checked.",
			sent_count, result_count);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- stereo_swept_dual_tap_delay_filter.f -----
sv/sdtf_pkg.sv
sv/sdtf_lane.sv
sv/sdtf_dp.sv
sv/sdtf_ctrl.sv
sv/stereo_swept_dual_tap_delay_filter.sv
verif/sdtf_checker.sv
verif/tb.sv
